/* hdl/sda_pkg.sv */
package sda_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ACC_WIDTH_DEF = 48;

	localparam int POS_W     = 32;
	localparam int MASS_W    = 32;
	localparam int CFG_W     = 32;
	localparam int LY_W      = 31;
	localparam int DENS_W    = 48;
	localparam int WRAP_W    = 2;
	localparam int CFG_IDX_W = 2;

	// |dx| and |dy| both fit 33 bits; dx^2 + dy^2 < 2^67
	localparam int MAG_W  = 33;
	localparam int RAD_W  = 68;
	localparam int ROOT_W = RAD_W / 2;

	// shared shift-add multiplier
	localparam int MUL_A_W = 44;
	localparam int MUL_B_W = 36;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_INV_H  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KSCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LY     = 2'd2;

	localparam logic [WRAP_W-1:0] WRAP_NONE = 2'd0;
	localparam logic [WRAP_W-1:0] WRAP_SUB  = 2'd1;
	localparam logic [WRAP_W-1:0] WRAP_ADD  = 2'd2;

	typedef struct packed {
		logic [MAG_W-1:0]  ux;
		logic [MAG_W-1:0]  uy;
		logic [MASS_W-1:0] mass;
		logic              first;
		logic              last;
	} pair_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

/* hdl/sda_in_if.sv */
interface sda_in_if import sda_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  self_x;
	logic signed [POS_W-1:0]  self_y;
	logic signed [POS_W-1:0]  other_x;
	logic signed [POS_W-1:0]  other_y;
	logic [MASS_W-1:0]        other_mass;
	logic [WRAP_W-1:0]        wrap_shift;
	logic                     first_pair;
	logic                     last_pair;

	modport source (output valid, self_x, self_y, other_x, other_y, other_mass, wrap_shift,
		first_pair, last_pair, input ready);
	modport sink (input valid, self_x, self_y, other_x, other_y, other_mass, wrap_shift,
		first_pair, last_pair, output ready);
endinterface

/* hdl/sda_out_if.sv */
interface sda_out_if import sda_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DENS_W-1:0] density;
	logic              saturated;

	modport source (output valid, density, saturated, input ready);
	modport sink (input valid, density, saturated, output ready);
endinterface

/* hdl/sda_cfg_if.sv */
interface sda_cfg_if import sda_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/sda_front.sv */
module sda_front import sda_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	sda_in_if.sink          pair,
	input  logic [LY_W-1:0] ly,
	output logic            push_valid,
	input  logic            push_ready,
	output pair_t           push_data
);

	logic signed [MAG_W-1:0] dx;
	logic signed [33:0]      oy;
	logic signed [34:0]      dy;
	logic [34:0]             dy_mag;
	pair_t                   cls;
	pair_t                   data_s1;
	logic                    valid_s1;

	always_comb begin
		dx = {pair.self_x[POS_W-1], pair.self_x} - {pair.other_x[POS_W-1], pair.other_x};
		oy = {{2{pair.other_y[POS_W-1]}}, pair.other_y};
		case (pair.wrap_shift)
			WRAP_SUB: oy = oy - $signed({3'b000, ly});
			WRAP_ADD: oy = oy + $signed({3'b000, ly});
			default:  oy = oy;
		endcase
		dy = {{3{pair.self_y[POS_W-1]}}, pair.self_y} - {oy[33], oy};
		dy_mag = dy[34] ? 35'(-dy) : 35'(dy);
		cls.ux    = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
		cls.uy    = dy_mag[MAG_W-1:0];
		cls.mass  = pair.other_mass;
		cls.first = pair.first_pair;
		cls.last  = pair.last_pair;
	end

	assign pair.ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pair.ready) begin
			valid_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.ready && pair.valid) begin
			data_s1 <= cls;
		end
	end

endmodule

/* hdl/sda_queue.sv */
module sda_queue import sda_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  pair_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output pair_t pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pair_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/sda_mul.sv */
module sda_mul import sda_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output mul_stat_t          stat,
	output logic [MUL_P_W-1:0] prod
);

	logic [MUL_P_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_P_W-1:0] acc_q;
	logic               busy_q;
	logic               done_q;

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

	// one multiplier bit per cycle, stops once the remaining bits are zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q[MUL_B_W-1:1] == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= MUL_P_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
		end
	end

endmodule

/* hdl/sda_back.sv */
module sda_back import sda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  pair_t            pop_data,
	input  logic [CFG_W-1:0] inv_h,
	input  logic [CFG_W-1:0] kernel_scale,
	sda_out_if.source        result
);

	localparam int QW = FRAC_BITS + 2;
	localparam int WW = FRAC_BITS + 12;
	localparam int CNT_W = $clog2(ROOT_W);
	localparam logic [QW-1:0] ONE   = QW'(1) << FRAC_BITS;
	localparam logic [QW-1:0] TWO   = QW'(2) << FRAC_BITS;
	localparam logic [QW-1:0] THREE = QW'(3) << FRAC_BITS;
	localparam logic [MUL_P_W-1:0] Q_LIM = MUL_P_W'(3) << (2 * FRAC_BITS);
	localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_QMUL, ST_P2, ST_P4, ST_P5,
		ST_KMUL, ST_CMUL, ST_ACC, ST_EMIT
	} state_t;

	state_t                 state_q;
	logic                   issued_q;
	pair_t                  item_q;
	logic [RAD_W-1:0]       rad_q;
	logic [ROOT_W+3:0]      rem_q;
	logic [ROOT_W-1:0]      root_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [QW-1:0]          q_q;
	logic [1:0]             term_q;
	logic [QW-1:0]          t_q;
	logic [MUL_B_W-1:0]     p_q;
	logic signed [WW-1:0]   w_q;
	logic [MUL_A_W-1:0]     k_q;
	logic [63:0]            contrib_q;
	logic                   big_q;
	logic [ACC_WIDTH-1:0]   acc_q;
	logic                   ov_q;
	logic                   out_valid_q;
	logic [DENS_W-1:0]      dens_q;
	logic                   sat_q;

	logic                   mul_state;
	logic                   mul_start;
	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	mul_stat_t              mul_stat;
	logic [MUL_P_W-1:0]     prod;
	logic [ROOT_W+3:0]      rem_sh;
	logic [ROOT_W+3:0]      trial;
	logic signed [WW-1:0]   p5;
	logic signed [WW-1:0]   w_next;
	logic [64:0]            total;
	logic                   out_free;

	sda_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (prod)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_state = 1'b1;
		case (state_q)
			ST_SQX: begin
				mul_a = MUL_A_W'(item_q.ux);
				mul_b = MUL_B_W'(item_q.ux);
			end
			ST_SQY: begin
				mul_a = MUL_A_W'(item_q.uy);
				mul_b = MUL_B_W'(item_q.uy);
			end
			ST_QMUL: begin
				mul_a = MUL_A_W'(inv_h);
				mul_b = MUL_B_W'(root_q);
			end
			ST_P2: begin
				mul_a = MUL_A_W'(t_q);
				mul_b = MUL_B_W'(t_q);
			end
			ST_P4: begin
				mul_a = MUL_A_W'(p_q);
				mul_b = p_q;
			end
			ST_P5: begin
				mul_a = MUL_A_W'(p_q);
				mul_b = MUL_B_W'(t_q);
			end
			ST_KMUL: begin
				mul_a = w_q[WW-1] ? '0 : MUL_A_W'(unsigned'(w_q));
				mul_b = MUL_B_W'(kernel_scale);
			end
			ST_CMUL: begin
				mul_a = k_q;
				mul_b = MUL_B_W'(item_q.mass);
			end
			default: mul_state = 1'b0;
		endcase
		mul_start = mul_state && !issued_q;
	end

	always_comb begin
		rem_sh = {rem_q[ROOT_W+1:0], rad_q[RAD_W-1:RAD_W-2]};
		trial  = {2'b00, root_q, 2'b01};
		p5 = signed'(WW'(prod >> FRAC_BITS));
		case (term_q)
			2'd1:    w_next = w_q - (p5 <<< 2) - (p5 <<< 1);
			2'd2:    w_next = w_q + (p5 <<< 4) - p5;
			default: w_next = w_q + p5;
		endcase
		total = 65'(acc_q) + 65'(contrib_q);
	end

	assign pop_ready        = state_q == ST_IDLE;
	assign out_free         = !out_valid_q || result.ready;
	assign result.valid     = out_valid_q;
	assign result.density   = dens_q;
	assign result.saturated = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			acc_q       <= '0;
			ov_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_start) begin
				issued_q <= 1'b1;
			end
			if (mul_state && issued_q && mul_stat.done) begin
				issued_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_SQX;
						if (pop_data.first) begin
							acc_q <= '0;
							ov_q  <= 1'b0;
						end
					end
				end
				ST_SQX: if (issued_q && mul_stat.done) state_q <= ST_SQY;
				ST_SQY: if (issued_q && mul_stat.done) state_q <= ST_ROOT;
				ST_ROOT: begin
					if (cnt_q == CNT_W'(ROOT_W - 1)) begin
						state_q <= ST_QMUL;
					end
				end
				ST_QMUL: begin
					if (issued_q && mul_stat.done) begin
						state_q <= (prod >= Q_LIM) ? ST_ACC : ST_P2;
					end
				end
				ST_P2: if (issued_q && mul_stat.done) state_q <= ST_P4;
				ST_P4: if (issued_q && mul_stat.done) state_q <= ST_P5;
				ST_P5: begin
					if (issued_q && mul_stat.done) begin
						if ((term_q == 2'd0 && q_q < TWO) || (term_q == 2'd1 && q_q < ONE)) begin
							state_q <= ST_P2;
						end else begin
							state_q <= ST_KMUL;
						end
					end
				end
				ST_KMUL: if (issued_q && mul_stat.done) state_q <= ST_CMUL;
				ST_CMUL: if (issued_q && mul_stat.done) state_q <= ST_ACC;
				ST_ACC: begin
					if (big_q || total > 65'(ACC_MAX)) begin
						acc_q <= ACC_MAX;
						ov_q  <= 1'b1;
					end else begin
						acc_q <= ACC_WIDTH'(total);
					end
					state_q <= item_q.last ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					item_q <= pop_data;
				end
				contrib_q <= '0;
				big_q     <= 1'b0;
			end
			ST_SQX: begin
				if (mul_stat.done) begin
					rad_q <= prod[RAD_W-1:0];
				end
			end
			ST_SQY: begin
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
				if (mul_stat.done) begin
					rad_q <= rad_q + prod[RAD_W-1:0];
				end
			end
			ST_ROOT: begin
				// restoring square root, one result bit per cycle
				rad_q <= rad_q << 2;
				cnt_q <= cnt_q + 1'b1;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			ST_QMUL: begin
				q_q    <= QW'(prod >> FRAC_BITS);
				t_q    <= THREE - QW'(prod >> FRAC_BITS);
				term_q <= 2'd0;
				w_q    <= '0;
			end
			ST_P2, ST_P4: begin
				if (mul_stat.done) begin
					p_q <= MUL_B_W'(prod >> FRAC_BITS);
				end
			end
			ST_P5: begin
				if (mul_stat.done) begin
					w_q    <= w_next;
					term_q <= term_q + 1'b1;
					t_q    <= (term_q == 2'd0) ? TWO - q_q : ONE - q_q;
				end
			end
			ST_KMUL: begin
				if (mul_stat.done) begin
					k_q <= MUL_A_W'(prod >> FRAC_BITS);
				end
			end
			ST_CMUL: begin
				if (mul_stat.done) begin
					contrib_q <= 64'(prod >> FRAC_BITS);
					big_q     <= (prod >> (64 + FRAC_BITS)) != '0;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					dens_q <= DENS_W'(acc_q);
					sat_q  <= ov_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// a saturated sum stays pinned until the next clear
	assert property (@(posedge clk) disable iff (!arst_n) ov_q |-> acc_q == ACC_MAX)
		else $error("overflow flag set with sum below maximum");
	assert property (@(posedge clk) disable iff (!arst_n) mul_start |-> !mul_stat.busy)
		else $error("multiplier started while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !out_valid_q) |=> out_valid_q)
		else $error("result not loaded into free output register");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !(pop_valid && pop_ready))
		else $error("queue popped while a pair is in flight");
`endif

endmodule

/* hdl/sph_density_accumulator.sv */
// channel | dir | payload
// pair    | in  | self_x, self_y, other_x, other_y, other_mass, wrap_shift, first_pair, last_pair
// result  | out | density, saturated
// cfg     | in  | index, data (0 inv_h, 1 kernel_scale, 2 domain_height)
//
// Front stage registers |dx|,|dy| and pushes a 2-word queue.
// Back end takes one pair at a time and works it through the shared shift-add
// multiplier (one operand bit per cycle, up to 14 products) and a 34-bit
// restoring square root. arst_n clears control state, sum and overflow flag;
// config resets to 1.0, 1.0, 16.0. Either side may stall; the result word is held
// in an output register while the back end and queue keep working.
module sph_density_accumulator import sda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	sda_in_if.sink   pair,
	sda_out_if.source result,
	sda_cfg_if.sink  cfg
);

	logic [CFG_W-1:0] inv_h_q;
	logic [CFG_W-1:0] kscale_q;
	logic [LY_W-1:0]  ly_q;
	logic             push_valid;
	logic             push_ready;
	pair_t            push_data;
	logic             pop_valid;
	logic             pop_ready;
	pair_t            pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_h_q  <= CFG_W'(32'h0001_0000);
			kscale_q <= CFG_W'(32'h0001_0000);
			ly_q     <= LY_W'(32'h0010_0000);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_INV_H:  inv_h_q  <= cfg.data;
				REG_KSCALE: kscale_q <= cfg.data;
				REG_LY:     ly_q     <= cfg.data[LY_W-1:0];
				default: ;
			endcase
		end
	end

	sda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.ly         (ly_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sda_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sda_back #(
		.FRAC_BITS (FRAC_BITS),
		.ACC_WIDTH (ACC_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.inv_h        (inv_h_q),
		.kernel_scale (kscale_q),
		.result       (result)
	);

endmodule

/* tb/sv/tb_sda_checker.sv */
`timescale 1ns / 100ps

module tb_sda_checker import sda_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sda_in_if    pair_mon,
	sda_out_if   res_mon,
	sda_cfg_if   cfg_mon,
	output int   fail_count,
	output int   pending,
	output int   checked
);

	localparam logic [63:0] ONE_Q   = 64'd1 << 16;
	localparam logic [47:0] DENS_MAX = '1;

	typedef struct packed {
		logic [DENS_W-1:0] density;
		logic              saturated;
	} density_word_t;

	density_word_t density_q[$];

	logic [CFG_W-1:0]  inv_h_r;
	logic [CFG_W-1:0]  sigma_r;
	logic [LY_W-1:0]   height_r;
	logic [DENS_W-1:0] sum_r;
	logic              clip_r;

	function automatic logic [63:0] pow5(logic [63:0] t);
		logic [63:0] p2, p4;
		p2 = (t * t) >> 16;
		p4 = (p2 * p2) >> 16;
		return (p4 * t) >> 16;
	endfunction

	// bitwise floor square root of the sum of squares
	function automatic logic [34:0] root68(logic [67:0] n);
		logic [34:0] acc, c;
		logic [69:0] sq;
		acc = '0;
		for (int b = 34; b >= 0; b--) begin
			c = acc | (35'd1 << b);
			sq = {35'd0, c} * {35'd0, c};
			if (sq <= {2'b00, n})
				acc = c;
		end
		return acc;
	endfunction

	// updates the running sum for one pair; queues the density word on last_pair
	task automatic accumulate_pair();
		longint        dx, dy, oy;
		logic [67:0]   ux, uy, sumsq;
		logic [34:0]   r;
		logic [66:0]   rq;
		logic [63:0]   q, k, contrib;
		longint        w;
		logic [95:0]   mk;
		logic          big;
		density_word_t word;
		dx = longint'(pair_mon.self_x) - longint'(pair_mon.other_x);
		oy = longint'(pair_mon.other_y);
		if (pair_mon.wrap_shift == WRAP_SUB)
			oy = oy - longint'({33'd0, height_r});
		else if (pair_mon.wrap_shift == WRAP_ADD)
			oy = oy + longint'({33'd0, height_r});
		dy = longint'(pair_mon.self_y) - oy;
		if (pair_mon.first_pair) begin
			sum_r = '0;
			clip_r = 1'b0;
		end
		ux = 68'(dx < 0 ? -dx : dx);
		uy = 68'(dy < 0 ? -dy : dy);
		sumsq = ux * ux + uy * uy;
		r = root68(sumsq);
		rq = {32'd0, r} * {35'd0, inv_h_r};
		contrib = '0;
		big = 1'b0;
		if (rq < (67'd3 << 32)) begin
			q = 64'(rq >> 16);
			w = longint'(pow5(3 * ONE_Q - q));
			if (q < 2 * ONE_Q)
				w = w - 6 * longint'(pow5(2 * ONE_Q - q));
			if (q < ONE_Q)
				w = w + 15 * longint'(pow5(ONE_Q - q));
			if (w < 0)
				w = 0;
			k = (64'(w) * {32'd0, sigma_r}) >> 16;
			mk = {64'd0, pair_mon.other_mass} * {32'd0, k};
			big = mk[95:80] != '0;
			contrib = mk[79:16];
		end
		if (big || contrib > ({16'd0, DENS_MAX} - {16'd0, sum_r})) begin
			sum_r = DENS_MAX;
			clip_r = 1'b1;
		end else begin
			sum_r = sum_r + contrib[47:0];
		end
		if (pair_mon.last_pair) begin
			word.density = sum_r;
			word.saturated = clip_r;
			density_q = {density_q, word};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		density_word_t want;
		if (!arst_n) begin
			inv_h_r = 32'd65536;
			sigma_r = 32'd65536;
			height_r = 31'd1048576;
			sum_r = '0;
			clip_r = 1'b0;
			density_q.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					REG_INV_H: inv_h_r = cfg_mon.data;
					REG_KSCALE: sigma_r = cfg_mon.data;
					REG_LY: height_r = cfg_mon.data[LY_W-1:0];
					default: ;
				endcase
			end
			if (res_mon.valid && res_mon.ready) begin
				if (density_q.size() == 0) begin
					$error("density word with none expected: density=%0h saturated=%0b",
						res_mon.density, res_mon.saturated);
					fail_count++;
				end else begin
					want = density_q.pop_front();
					checked++;
					if (res_mon.density !== want.density) begin
						$error("density: expected %0h, got %0h", want.density, res_mon.density);
						fail_count++;
					end
					if (res_mon.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b", want.saturated,
							res_mon.saturated);
						fail_count++;
					end
				end
			end
			if (pair_mon.valid && pair_mon.ready)
				accumulate_pair();
		end
		pending = density_q.size();
	end

endmodule

/* tb/sv/tb_sph_density_accumulator.sv */
`timescale 1ns / 100ps

module tb_sph_density_accumulator;
	import sda_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [WRAP_W-1:0]    WRAP_ODD   = 2'd3;
	localparam int                   DRAIN_CYC  = 2500;
	localparam int                   NUM_PHASES = 8;
	localparam int                   PHASE_PAIRS = 190;

	typedef struct {
		logic signed [31:0] sx, sy, ox, oy;
		logic [31:0]        mass;
		logic [1:0]         wrap;
		logic               first, last;
	} pair_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending, checked;
	int   n_sent = 0;
	int   burst_left = 0;
	bit   no_gaps = 0;
	bit   hold_req = 0;
	logic [31:0] cur_inv_h = 32'd65536;
	logic [30:0] cur_ly = 31'd1048576;

	sda_in_if  pair_if();
	sda_out_if res_if();
	sda_cfg_if cfg_if();

	sph_density_accumulator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	tb_sda_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_mon   (pair_if),
		.res_mon    (res_if),
		.cfg_mon    (cfg_if),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #10 clk = ~clk;

	initial begin
		#60_000_000;
		$display("Some tests failed");
		$finish;
	end

	// receiver: one long hold-off on request, otherwise rotating stall patterns
	initial begin
		int  cyc;
		int  mode;
		bit  held;
		cyc = 0;
		held = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_req && !held) begin
				held = 1;
				res_if.ready <= 1'b0;
				repeat (3000) @(negedge clk);
			end
			mode = (cyc / 500) % 3;
			case (mode)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= ($urandom_range(0, 1) == 1);
				default: res_if.ready <= ((cyc % 7) >= 3);
			endcase
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	task automatic load_regs(logic [31:0] ih, logic [31:0] ks, logic [30:0] ly, bit extra);
		write_reg(REG_INV_H, ih);
		write_reg(REG_KSCALE, ks);
		write_reg(REG_LY, {1'b0, ly});
		if (extra)
			write_reg(REG_UNUSED, $urandom());
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		cur_inv_h = ih;
		cur_ly = ly;
	endtask

	// stop offering pairs, then let every word in flight drain
	task automatic wait_quiet();
		@(negedge clk);
		pair_if.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic send_pair(pair_word_t p);
		@(negedge clk);
		pair_if.valid <= 1'b1;
		pair_if.self_x <= p.sx;
		pair_if.self_y <= p.sy;
		pair_if.other_x <= p.ox;
		pair_if.other_y <= p.oy;
		pair_if.other_mass <= p.mass;
		pair_if.wrap_shift <= p.wrap;
		pair_if.first_pair <= p.first;
		pair_if.last_pair <= p.last;
		do @(posedge clk); while (!pair_if.ready);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			if (!no_gaps) begin
				@(negedge clk);
				pair_if.valid <= 1'b0;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end
		end
	endtask

	function automatic pair_word_t mk_pair(logic signed [31:0] sx, sy, ox, oy,
		logic [31:0] m, logic [1:0] w, logic f, l);
		pair_word_t p;
		p.sx = sx; p.sy = sy; p.ox = ox; p.oy = oy;
		p.mass = m; p.wrap = w; p.first = f; p.last = l;
		return p;
	endfunction

	// one particle: self pair, then neighbors within about 3h; sometimes broken
	task automatic send_particle();
		int          n;
		longint      span;
		logic signed [31:0] sx, sy;
		longint      ddx, ddy;
		logic [1:0]  w;
		logic [31:0] m;
		pair_word_t  p;
		bit          drop_first, drop_last;
		n = $urandom_range(1, 6);
		span = (longint'(3) << 32) / longint'(cur_inv_h);
		if (span > (longint'(1) << 30)) span = longint'(1) << 30;
		if (span < 2) span = 2;
		sx = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 24);
		sy = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 24);
		drop_first = ($urandom_range(0, 19) == 0);
		drop_last = ($urandom_range(0, 19) == 0);
		for (int i = 0; i < n; i++) begin
			m = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1 << 20);
			if (i == 0) begin
				p = mk_pair(sx, sy, sx, sy, m, WRAP_NONE, !drop_first, n == 1 && !drop_last);
			end else begin
				ddx = longint'($urandom_range(0, 32'(span))) - span / 2;
				ddy = longint'($urandom_range(0, 32'(span))) - span / 2;
				w = 2'($urandom_range(0, 3));
				if (w == WRAP_SUB) ddy = ddy + longint'(cur_ly);
				else if (w == WRAP_ADD) ddy = ddy - longint'(cur_ly);
				p = mk_pair(sx, sy, 32'(longint'(sx) + ddx), 32'(longint'(sy) + ddy), m, w,
					1'b0, i == n - 1 && !drop_last);
			end
			send_pair(p);
		end
	endtask

	task automatic send_noise();
		send_pair(mk_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
	endtask

	initial begin
		int start;
		pair_if.valid = 1'b0;
		pair_if.self_x = '0;
		pair_if.self_y = '0;
		pair_if.other_x = '0;
		pair_if.other_y = '0;
		pair_if.other_mass = '0;
		pair_if.wrap_shift = WRAP_NONE;
		pair_if.first_pair = 1'b0;
		pair_if.last_pair = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_INV_H;
		cfg_if.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, h = 1.0, Ly = 16.0
		no_gaps = 1;
		send_pair(mk_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'hFFFF_FFFF, WRAP_NONE, 1'b1, 1'b1));  // far apart: skipped
		send_pair(mk_pair(0, 0, 0, 0, 32'hFFFF_FFFF, WRAP_NONE, 1'b1, 1'b1));  // self pair
		send_pair(mk_pair(-1, -1, -1, -1, 32'h0, WRAP_NONE, 1'b1, 1'b1));  // zero mass
		send_pair(mk_pair(0, 0, 32'sd65536, 0, 32'h10000, WRAP_NONE, 1'b1, 1'b0));  // q = 1
		send_pair(mk_pair(0, 0, 32'sd131072, 0, 32'h10000, WRAP_NONE, 1'b0, 1'b0));  // q = 2
		send_pair(mk_pair(0, 0, 32'sd196607, 0, 32'h10000, WRAP_NONE, 1'b0, 1'b0));  // under 3
		send_pair(mk_pair(0, 0, 32'sd196608, 0, 32'h10000, WRAP_NONE, 1'b0, 1'b1));  // skip
		send_pair(mk_pair(0, 0, 0, 32'sd1048576, 32'h10000, WRAP_SUB, 1'b1, 1'b0));
		send_pair(mk_pair(0, 0, 0, -32'sd1048576, 32'h10000, WRAP_ADD, 1'b0, 1'b0));
		send_pair(mk_pair(0, 0, 0, 32'sd1048576, 32'h10000, WRAP_ODD, 1'b0, 1'b1));
		send_pair(mk_pair(5, 5, 5, 5, 32'h1234, WRAP_NONE, 1'b0, 1'b1));  // keeps summing
		for (int i = 0; i < 6; i++)  // six max-mass self pairs summed into one density
			send_pair(mk_pair(0, 0, 0, 0, 32'hFFFF_FFFF, WRAP_NONE, i == 0, i == 5));
		send_pair(mk_pair(0, 0, 32'sd1000, 32'sd1000, 32'h8000_0000, WRAP_NONE, 1'b0, 1'b1));
		no_gaps = 0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_quiet();
			case (ph)
				0: load_regs(32'd1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
				1: load_regs(32'hFFFF_FFFF, 32'd0, 31'd0, 1'b0);
				2: load_regs(32'd65536, 32'd65536, 31'd1048576, 1'b0);
				3: load_regs(32'd65536, 32'hFFFF_FFFF, 31'd1 << 20, 1'b0);
				default: load_regs($urandom_range(1 << 12, 1 << 20), $urandom_range(0, 1 << 22),
					31'($urandom_range(0, 32'h7FFF_FFFF)), ph == 4);
			endcase
			hold_req = (ph == 2);
			no_gaps = (ph == 5);
			start = n_sent;
			while (n_sent - start < PHASE_PAIRS) begin
				if ($urandom_range(0, 99) < 85)
					send_particle();
				else
					send_noise();
			end
		end

		@(negedge clk);
		pair_if.valid <= 1'b0;
		wait_quiet();
		$display("Covered %0d pairs under %0d register settings; %0d densities compared.",
			n_sent, NUM_PHASES + 1, checked);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
